// File: sv/samseq_pkg.sv
// ---------------------------------------------------------------------------
// samseq_pkg: shared types and constants of the single-axis motion sequencer
// Command bit positions, state codes and beat layout widths.
// ---------------------------------------------------------------------------
package samseq_pkg;

  localparam int unsigned CMD_W = 10;

  // command bit positions
  localparam int unsigned CMD_POWER = 0;
  localparam int unsigned CMD_STOP  = 1;
  localparam int unsigned CMD_HOME  = 2;
  localparam int unsigned CMD_JOGP  = 3;
  localparam int unsigned CMD_JOGN  = 4;
  localparam int unsigned CMD_ABS   = 5;
  localparam int unsigned CMD_ADD   = 6;
  localparam int unsigned CMD_VEL   = 7;
  localparam int unsigned CMD_HALT  = 8;
  localparam int unsigned CMD_ACK   = 9;

  // stop, home, jog, abs, add, vel
  localparam logic [CMD_W-1:0] CMD_MOTION_MASK = 10'b00_1111_1110;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [3:0] {
    ST_WAIT  = 4'd0,
    ST_PWRON = 4'd1,
    ST_HOME  = 4'd2,
    ST_READY = 4'd3,
    ST_HALT  = 4'd4,
    ST_STOP  = 4'd5,
    ST_JOGP  = 4'd6,
    ST_JOGN  = 4'd7,
    ST_ABS   = 4'd8,
    ST_ADD   = 4'd9,
    ST_VEL   = 4'd10,
    ST_AXERR = 4'd11,
    ST_ERR   = 4'd12,
    ST_RESET = 4'd13,
    ST_READ  = 4'd14
  } state_t;

endpackage

// File: sv/single_axis_motion_sequencer_core.sv
// ---------------------------------------------------------------------------
// single_axis_motion_sequencer_core
// One sequencer tick per input beat: latch commands, apply overrides, step
// the axis state machine and emit one result beat.
// ---------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata  (72 bits, tick inputs)
//  out_    | out | out_tvalid/out_tready| out_tdata (40 bits, tick results)
//  cfg_    | in  | cfg_wr_en            | cfg_wr_data (home_on_power)
//
//  One beat per clock while no result is stalled; the result shows in the cycle after the input beat.
//  The state update and its result register are the only loop: one tick
//  per cycle. in_tready drops only while a result beat is stalled.
//  rst_n is synchronous: state goes to wait, commands, error hold, drive
//  enable and home_on_power clear.
// ---------------------------------------------------------------------------
module single_axis_motion_sequencer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // command_set[9:0], command_clear[19:10], step_done[20], step_error[21],
  // step_error_code[37:22], power_fault[38], errorstop_seen[39],
  // axis_error_valid[40], axis_error_id[56:41], axis_error_count[64:57],
  // partner_synchronized[65], zero fill [71:66]
  input  logic [samseq_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // step_state[3:0], drive_enable[4], execute_request[5],
  // held_error_code[21:6], axis_ack_pulse[22], partner_gear_out[23],
  // pending_commands[33:24], zero fill [39:34]
  output logic [samseq_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int unsigned CW = samseq_pkg::CMD_W;

  samseq_pkg::state_t step_r, step_nxt;
  logic [CW-1:0]      cmd_r, cmd_nxt;
  logic [15:0]        hold_r, hold_nxt;
  logic               preq_r, preq_nxt;
  logic               home_on_power_r;
  logic               out_valid_r;
  logic [samseq_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic exec, ackp, gear, in_acc;

  // input fields
  logic [CW-1:0] cset, cclr;
  logic          done, err, pfault, estop, axvalid, psync;
  logic [15:0]   ecode, axid;
  logic [7:0]    axcount;

  assign cset    = in_tdata[9:0];
  assign cclr    = in_tdata[19:10];
  assign done    = in_tdata[20];
  assign err     = in_tdata[21];
  assign ecode   = in_tdata[37:22];
  assign pfault  = in_tdata[38];
  assign estop   = in_tdata[39];
  assign axvalid = in_tdata[40];
  assign axid    = in_tdata[56:41];
  assign axcount = in_tdata[64:57];
  assign psync   = in_tdata[65];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    logic [CW-1:0]      c;
    samseq_pkg::state_t s;
    logic [15:0]        h;
    logic               p;
    logic               jog_bit;

    c    = (cmd_r & ~cclr) | cset;
    s    = step_r;
    h    = hold_r;
    p    = preq_r;
    exec = 1'b0;
    ackp = 1'b0;
    gear = 1'b0;
    jog_bit = 1'b0;

    if (s > samseq_pkg::ST_READ) begin
      s = samseq_pkg::ST_WAIT;
    end

    // stop preempts ready through axis error
    if (c[samseq_pkg::CMD_STOP] && s >= samseq_pkg::ST_READY &&
        s <= samseq_pkg::ST_AXERR) begin
      c = c & ~samseq_pkg::CMD_MOTION_MASK;
      s = samseq_pkg::ST_STOP;
    end
    if (axvalid && axid != 16'd0) begin
      s = samseq_pkg::ST_AXERR;
    end else if (!c[samseq_pkg::CMD_POWER] && axvalid) begin
      s = estop ? samseq_pkg::ST_RESET : samseq_pkg::ST_WAIT;
    end

    case (s)
      samseq_pkg::ST_WAIT: begin
        if (c[samseq_pkg::CMD_POWER]) s = samseq_pkg::ST_PWRON;
        else p = 1'b0;
        c = c & ~samseq_pkg::CMD_MOTION_MASK;
        h = 16'd0;
      end
      samseq_pkg::ST_PWRON: begin
        p    = 1'b1;
        exec = 1'b1;
        if (done) begin
          if (home_on_power_r) c[samseq_pkg::CMD_HOME] = 1'b1;
          s = samseq_pkg::ST_READY;
        end
        if (err) begin
          h = ecode;
          s = samseq_pkg::ST_ERR;
        end
      end
      samseq_pkg::ST_READY: begin
        if (c[samseq_pkg::CMD_HOME]) begin
          c[samseq_pkg::CMD_HOME] = 1'b0;
          s = samseq_pkg::ST_HOME;
        end else if (c[samseq_pkg::CMD_STOP]) begin
          s = samseq_pkg::ST_STOP;
        end else if (c[samseq_pkg::CMD_JOGP]) begin
          s = samseq_pkg::ST_JOGP;
        end else if (c[samseq_pkg::CMD_JOGN]) begin
          s = samseq_pkg::ST_JOGN;
        end else if (c[samseq_pkg::CMD_ABS]) begin
          c[samseq_pkg::CMD_ABS] = 1'b0;
          s = samseq_pkg::ST_ABS;
        end else if (c[samseq_pkg::CMD_ADD]) begin
          c[samseq_pkg::CMD_ADD] = 1'b0;
          s = samseq_pkg::ST_ADD;
        end else if (c[samseq_pkg::CMD_VEL]) begin
          c[samseq_pkg::CMD_VEL] = 1'b0;
          s = samseq_pkg::ST_VEL;
        end else if (c[samseq_pkg::CMD_HALT]) begin
          c[samseq_pkg::CMD_HALT] = 1'b0;
          s = samseq_pkg::ST_HALT;
        end
      end
      samseq_pkg::ST_HOME: begin
        if (!psync) begin
          exec = 1'b1;
          if (done) begin
            exec = 1'b0;
            s = samseq_pkg::ST_READ;
          end
          if (err) begin
            exec = 1'b0;
            h = ecode;
            s = samseq_pkg::ST_ERR;
          end
        end else begin
          s    = samseq_pkg::ST_READ;
          gear = 1'b1;
        end
      end
      samseq_pkg::ST_HALT: begin
        exec = 1'b1;
        if (done) begin
          exec = 1'b0;
          s = samseq_pkg::ST_READY;
        end
        if (err) begin
          exec = 1'b0;
          h = ecode;
          s = samseq_pkg::ST_ERR;
        end
      end
      samseq_pkg::ST_STOP: begin
        exec = 1'b1;
        if (done && !c[samseq_pkg::CMD_STOP]) begin
          exec = 1'b0;
          s = samseq_pkg::ST_READY;
        end
        if (err) begin
          exec = 1'b0;
          h = ecode;
          s = samseq_pkg::ST_ERR;
        end
      end
      samseq_pkg::ST_JOGP, samseq_pkg::ST_JOGN: begin
        exec    = 1'b1;
        jog_bit = (s == samseq_pkg::ST_JOGP) ? c[samseq_pkg::CMD_JOGP]
                                             : c[samseq_pkg::CMD_JOGN];
        if (!jog_bit) begin
          exec = 1'b0;
          s = samseq_pkg::ST_HALT;
        end
        if (err) begin
          exec = 1'b0;
          h = ecode;
          s = samseq_pkg::ST_ERR;
        end
      end
      samseq_pkg::ST_ABS, samseq_pkg::ST_ADD, samseq_pkg::ST_VEL: begin
        exec = 1'b1;
        if (c[samseq_pkg::CMD_HALT]) begin
          c[samseq_pkg::CMD_HALT] = 1'b0;
          exec = 1'b0;
          s = samseq_pkg::ST_HALT;
        end else if (done) begin
          exec = 1'b0;
          s = samseq_pkg::ST_READY;
        end
        if (err) begin
          exec = 1'b0;
          h = ecode;
          s = samseq_pkg::ST_ERR;
        end
      end
      samseq_pkg::ST_ERR: begin
        if (axcount != 8'd0) begin
          s = samseq_pkg::ST_AXERR;
        end else if (c[samseq_pkg::CMD_ACK]) begin
          c[samseq_pkg::CMD_ACK] = 1'b0;
          h = 16'd0;
          s = estop ? samseq_pkg::ST_RESET : samseq_pkg::ST_WAIT;
        end
      end
      samseq_pkg::ST_AXERR: begin
        if (axvalid) begin
          if (axid != 16'd0) h = axid;
          if (c[samseq_pkg::CMD_ACK]) begin
            c[samseq_pkg::CMD_ACK] = 1'b0;
            if (axid != 16'd0) ackp = 1'b1;
          end
          if (axcount == 8'd0) begin
            h = 16'd0;
            s = estop ? samseq_pkg::ST_RESET : samseq_pkg::ST_WAIT;
          end
        end
      end
      samseq_pkg::ST_RESET: begin
        exec = 1'b1;
        if (pfault) p = 1'b0;
        if (done) begin
          exec = 1'b0;
          s = samseq_pkg::ST_WAIT;
        end else if (err) begin
          exec = 1'b0;
          s = samseq_pkg::ST_ERR;
        end
      end
      default: begin
        // read: enable stays up on the tick back to ready
        exec = 1'b1;
        if (done) begin
          s = samseq_pkg::ST_READY;
        end else if (err) begin
          h = ecode;
          exec = 1'b0;
          s = samseq_pkg::ST_ERR;
        end
      end
    endcase

    step_nxt = s;
    cmd_nxt  = c;
    hold_nxt = h;
    preq_nxt = p;
    out_data_nxt = {6'd0, c, gear, ackp, h, exec, p, s};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r          <= samseq_pkg::ST_WAIT;
      cmd_r           <= '0;
      hold_r          <= '0;
      preq_r          <= 1'b0;
      home_on_power_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) home_on_power_r <= cfg_wr_data;
      if (in_acc) begin
        step_r <= step_nxt;
        cmd_r  <= cmd_nxt;
        hold_r <= hold_nxt;
        preq_r <= preq_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // stalled result blocks the input side
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while result beat stalled");

  // every accepted beat yields a result beat
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted beat produced no result");

  // shown result matches the live sequencer state
  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33:24] == cmd_r && out_tdata[21:6] == hold_r &&
                    out_tdata[3:0] == step_r && out_tdata[4] == preq_r))
    else $error("result beat out of step with sequencer state");

endmodule
